### rtl/clc_pkg.sv
// Shared types and constants for the causal linear convolution unit.
package clc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 32;
	localparam int CONV_W   = 43;
	localparam int INDEX_W  = 10;
	localparam int RLEN_W   = 11;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [RLEN_W-1:0] RECORD_LENGTH_RESET = 11'd1024;
	localparam logic              REG_RECORD_LENGTH   = 1'b0;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_a;
		logic signed [SAMPLE_W-1:0] sample_b;
		logic                       first;
	} in_t;

	typedef struct packed {
		logic signed [CONV_W-1:0] conv_value;
		logic [INDEX_W-1:0]       sample_index;
		logic                     last_of_record;
		logic                     overrun;
	} out_t;

	typedef struct packed {
		logic clr_acc;
		logic wr_en;
		logic rd_en;
		logic ld_result;
		logic ld_overrun;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

### rtl/clc_regs.sv
// APB configuration register block for the convolution unit.
module clc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [clc_pkg::PADDR_W-1:0]   paddr,
	input  logic [clc_pkg::PDATA_W-1:0]   pwdata,
	output logic [clc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [clc_pkg::RLEN_W-1:0]    record_length
);

	logic [clc_pkg::RLEN_W-1:0] record_length_q;
	logic                       sel_rlen;

	assign pready        = 1'b1;
	assign sel_rlen      = (paddr[clc_pkg::PADDR_W-1] == clc_pkg::REG_RECORD_LENGTH);
	assign record_length = record_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q <= clc_pkg::RECORD_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && sel_rlen) begin
			record_length_q <= pwdata[clc_pkg::RLEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_rlen) begin
			prdata = clc_pkg::PDATA_W'(record_length_q);
		end
	end

endmodule

### rtl/clc_dp.sv
// Datapath: sample stores, shared multiply-accumulate pipeline and result register.
module clc_dp #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clc_pkg::cmd_t        cmd,
	input  logic [$clog2(MAX_SAMPLES)-1:0] wr_addr,
	input  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr_a,
	input  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr_b,
	input  logic [$clog2(MAX_SAMPLES)-1:0] cur_index,
	input  clc_pkg::in_t         sample,
	input  logic                 result_ready,
	output clc_pkg::status_t     status,
	output logic                 result_valid,
	output clc_pkg::out_t        result
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int SUM_W = clc_pkg::PROD_W + IDX_W;
	localparam int ACC_W = (SUM_W > clc_pkg::CONV_W) ? SUM_W : clc_pkg::CONV_W;
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-clc_pkg::CONV_W+1){1'b0}}, {(clc_pkg::CONV_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W-clc_pkg::CONV_W+1){1'b1}}, {(clc_pkg::CONV_W-1){1'b0}}};

	logic signed [clc_pkg::SAMPLE_W-1:0] mem_a [MAX_SAMPLES];
	logic signed [clc_pkg::SAMPLE_W-1:0] mem_b [MAX_SAMPLES];

	logic signed [clc_pkg::SAMPLE_W-1:0] a_s1;
	logic signed [clc_pkg::SAMPLE_W-1:0] b_s1;
	logic                                valid_s1;
	logic signed [clc_pkg::PROD_W-1:0]   prod_s2;
	logic                                valid_s2;
	logic signed [ACC_W-1:0]             acc_q;
	logic signed [ACC_W-1:0]             acc_sat;
	logic                                result_valid_q;
	clc_pkg::out_t                       result_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_a[wr_addr] <= sample.sample_a;
			mem_b[wr_addr] <= sample.sample_b;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			a_s1 <= mem_a[rd_addr_a];
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= a_s1 * b_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		acc_sat = acc_q;
		if (acc_q > SAT_MAX) begin
			acc_sat = SAT_MAX;
		end else if (acc_q < SAT_MIN) begin
			acc_sat = SAT_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.ld_result || cmd.ld_overrun) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_result) begin
			result_q.conv_value     <= clc_pkg::CONV_W'(acc_sat);
			result_q.sample_index   <= clc_pkg::INDEX_W'(cur_index);
			result_q.last_of_record <= cmd.last;
			result_q.overrun        <= 1'b0;
		end else if (cmd.ld_overrun) begin
			result_q.conv_value     <= '0;
			result_q.sample_index   <= '0;
			result_q.last_of_record <= 1'b0;
			result_q.overrun        <= 1'b1;
		end
	end

	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_free  = !result_valid_q || result_ready;
	assign result_valid     = result_valid_q;
	assign result           = result_q;

endmodule

### rtl/clc_ctrl.sv
// Controller: record indexing, length checks and multiply-accumulate sequencing.
module clc_ctrl #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic                              first,
	input  logic [clc_pkg::RLEN_W-1:0]        record_length,
	input  clc_pkg::status_t                  status,
	output clc_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_SAMPLES)-1:0]    wr_addr,
	output logic [$clog2(MAX_SAMPLES)-1:0]    rd_addr_a,
	output logic [$clog2(MAX_SAMPLES)-1:0]    rd_addr_b,
	output logic [$clog2(MAX_SAMPLES)-1:0]    cur_index
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int LEN_W = (CNT_W > clc_pkg::RLEN_W) ? CNT_W : clc_pkg::RLEN_W;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SAMPLES);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_OVR
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  next_q;
	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  k_q;
	logic              last_q;

	logic [CNT_W-1:0]  n_in;
	logic [LEN_W-1:0]  n_ext;
	logic [LEN_W-1:0]  rlen_ext;
	logic [LEN_W-1:0]  eff_len;
	logic              accept;
	logic              over;

	assign n_in     = first ? '0 : next_q;
	assign n_ext    = LEN_W'(n_in);
	assign rlen_ext = LEN_W'(record_length);

	always_comb begin
		eff_len = rlen_ext;
		if (rlen_ext == '0) begin
			eff_len = LEN_ONE;
		end else if (rlen_ext > LEN_MAX) begin
			eff_len = LEN_MAX;
		end
	end

	assign over         = (n_ext >= eff_len);
	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;

	assign wr_addr   = IDX_W'(n_in);
	assign rd_addr_a = k_q;
	assign rd_addr_b = n_q - k_q;
	assign cur_index = n_q;

	always_comb begin
		cmd            = '0;
		cmd.last       = last_q;
		cmd.clr_acc    = accept && !over;
		cmd.wr_en      = accept && !over;
		cmd.rd_en      = (state_q == ST_MAC);
		cmd.ld_result  = (state_q == ST_DRAIN) && !status.pipe_busy && status.out_free;
		cmd.ld_overrun = (state_q == ST_OVR) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_q  <= '0;
			n_q     <= '0;
			k_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (over) begin
							state_q <= ST_OVR;
						end else begin
							n_q     <= IDX_W'(n_in);
							k_q     <= '0;
							last_q  <= (n_ext == eff_len - LEN_ONE);
							next_q  <= n_in + CNT_W'(1);
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy && status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_OVR: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/causal_linear_convolution_unit.sv
// Top level of the truncated causal linear convolution unit.
//
//  channel   direction  handshake                      payload
//  sample    in         sample_valid / sample_ready    clc_pkg::in_t
//  result    out        result_valid / result_ready    clc_pkg::out_t
//  config    in         APB psel/penable/pready        record_length at byte 0
//
// A request at index n has its result formed by the single
// shared multiply-accumulate that walks k = 0..n over the sample stores and its two-stage
// product pipeline. An overrun request raises its result via the overrun state, once the result register is free.
// The next request is taken only once the previous one has reached the result register.
// Reset clears the record index and state; sample stores are not cleared.
// A stalled result holds in the result register and holds back the next result.
module causal_linear_convolution_unit #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  clc_pkg::in_t                  sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output clc_pkg::out_t                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [clc_pkg::PADDR_W-1:0]   paddr,
	input  logic [clc_pkg::PDATA_W-1:0]   pwdata,
	output logic [clc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);

	logic [clc_pkg::RLEN_W-1:0] record_length;
	clc_pkg::cmd_t              cmd;
	clc_pkg::status_t           status;
	logic [IDX_W-1:0]           wr_addr;
	logic [IDX_W-1:0]           rd_addr_a;
	logic [IDX_W-1:0]           rd_addr_b;
	logic [IDX_W-1:0]           cur_index;

	clc_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.record_length (record_length)
	);

	clc_ctrl #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.first         (sample.first),
		.record_length (record_length),
		.status        (status),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr_a     (rd_addr_a),
		.rd_addr_b     (rd_addr_b),
		.cur_index     (cur_index)
	);

	clc_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.cur_index    (cur_index),
		.sample       (sample),
		.result_ready (result_ready),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
